/* sv/lfo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_pkg: shared types, codes and constants of the modulation source
// Register and mode codes, the serial multiplier request, fixed widths and
// the series helpers used to build the sine and ramp tables at elaboration.
// ----------------------------------------------------------------------------
package lfo_pkg;

	// Fixed field widths
	localparam int PHASE_W     = 32;
	localparam int SAMPLE_W    = 16;
	localparam int MODE_W      = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	// Table depths and ratio defaults
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int RAMP_DEPTH_DEF = 256;
	localparam int RAMP_RATIO_DEF = 100;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED             = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEPTH             = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_FULL_STEP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FAST_FULL_STEP    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FASTEST_RAMP_STEP = 3'd5;

	// Wave modes
	localparam logic [MODE_W-1:0] MODE_SLOW_SINE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FAST_SINE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RAMP_UP   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RAMP_DOWN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIN_UP    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LIN_DOWN  = 3'd5;

	// Ramp full scale, Q1.31
	localparam logic [PHASE_W-1:0] RAMP_ONE = 32'h8000_0000;

	// Serial multiplier: 32 x 32, one 2-bit digit of b per cycle
	localparam int MUL_W       = 32;
	localparam int MUL_P_W     = 2 * MUL_W;
	localparam int DIGIT_W     = 2;
	localparam int MUL_CNT_W   = $clog2(MUL_W / DIGIT_W + 1);
	localparam logic [MUL_CNT_W-1:0] MUL_FULL_DIGITS = MUL_CNT_W'(MUL_W / DIGIT_W);
	localparam logic [MUL_CNT_W-1:0] MUL_HALF_DIGITS = MUL_CNT_W'(SAMPLE_W / DIGIT_W);

	typedef struct packed {
		logic                 start;
		logic [MUL_CNT_W-1:0] digits;
	} mul_req_t;

	// Table build constants, Q30
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] LN2_Q30     = 64'd744261118;

	function automatic logic [63:0] sin_term_div(input logic [63:0] term, input int k);
		logic [63:0] q;
		unique case (k)
			1: q = term / 64'd6;
			2: q = term / 64'd20;
			3: q = term / 64'd42;
			4: q = term / 64'd72;
			5: q = term / 64'd110;
			6: q = term / 64'd156;
			default: q = term / 64'd210;
		endcase
		return q;
	endfunction

	function automatic logic [63:0] exp_term_div(input logic [63:0] term, input int k);
		logic [63:0] q;
		unique case (k)
			1: q = term;
			2: q = term / 64'd2;
			3: q = term / 64'd3;
			4: q = term / 64'd4;
			5: q = term / 64'd5;
			6: q = term / 64'd6;
			7: q = term / 64'd7;
			8: q = term / 64'd8;
			9: q = term / 64'd9;
			10: q = term / 64'd10;
			11: q = term / 64'd11;
			12: q = term / 64'd12;
			13: q = term / 64'd13;
			default: q = term / 64'd14;
		endcase
		return q;
	endfunction

	// sin(x), x in [0, pi/2], Q30 in and out
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic signed [63:0] sum;
		logic [63:0] term;
		sum = $signed(x);
		term = x;
		for (int k = 1; k <= 7; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = sin_term_div(term, k);
			if (k[0])
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		return (sum < 64'sd0) ? 64'd0 : $unsigned(sum);
	endfunction

	// exp(-z), z in [0, 1), Q30 in and out
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] z);
		logic signed [63:0] sum;
		logic [63:0] term;
		sum = $signed(ONE_Q30);
		term = ONE_Q30;
		for (int k = 1; k <= 14; k++) begin
			term = exp_term_div((term * z) >> 30, k);
			if (k[0])
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		return (sum < 64'sd0) ? 64'd0 : $unsigned(sum);
	endfunction

	// log2(r), r >= 1, Q30
	function automatic logic [63:0] log2_q30(input logic [63:0] r_in);
		logic [63:0] r;
		logic [63:0] n;
		logic [63:0] m;
		logic [63:0] frac;
		r = (r_in < 64'd1) ? 64'd1 : r_in;
		n = 64'd0;
		frac = 64'd0;
		for (int j = 0; j < 40; j++) begin
			if ((r >> (n + 64'd1)) != 64'd0)
				n = n + 64'd1;
		end
		m = (n <= 64'd30) ? (r << (64'd30 - n)) : (r >> (n - 64'd30));
		for (int b = 29; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 2 * ONE_Q30) begin
				frac = frac | (64'd1 << b);
				m = m >> 1;
			end
		end
		return (n << 30) | frac;
	endfunction

endpackage

`default_nettype wire

/* sv/lfo_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_in_if: trigger word channel
// Carries attack and decay triggers and the ramp time control.
// ----------------------------------------------------------------------------
interface lfo_in_if;
	logic        valid;
	logic        ready;
	logic        attack_trigger;
	logic        decay_trigger;
	logic [15:0] ramp_amount;

	modport source (
		output valid,
		output attack_trigger,
		output decay_trigger,
		output ramp_amount,
		input  ready
	);

	modport sink (
		input  valid,
		input  attack_trigger,
		input  decay_trigger,
		input  ramp_amount,
		output ready
	);
endinterface

`default_nettype wire

/* sv/lfo_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_out_if: modulation sample channel
// Carries one unipolar Q0.16 level word.
// ----------------------------------------------------------------------------
interface lfo_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;

	modport source (
		output valid,
		output level,
		input  ready
	);

	modport sink (
		input  valid,
		input  level,
		output ready
	);
endinterface

`default_nettype wire

/* sv/lfo_with_triggered_ramp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_with_triggered_ramp: sine LFO with trigger-driven ramp envelope
// Free sine modes read a sine table at a free-running Q0.32 phase; ramp
// modes drive a Q1.31 envelope from triggers and shape the output with it.
// ----------------------------------------------------------------------------
// Words are taken only in the idle state, so a new word waits until the
// level of the last one is loaded. The shared 2-bit-per-cycle serial
// multiplier runs every product of a word one after the other.
// Reset clears the configuration and control registers, both phases and the ramp; the tables are
// constants and need no fill.
// ----------------------------------------------------------------------------
module lfo_with_triggered_ramp #(
	parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEF,
	parameter int RAMP_TABLE_DEPTH = lfo_pkg::RAMP_DEPTH_DEF,
	parameter int RAMP_TIME_RATIO  = lfo_pkg::RAMP_RATIO_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	lfo_in_if.sink                             events,
	lfo_out_if.source                          samples,
	input  wire                                cfg_wr_en,
	input  wire  [lfo_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [lfo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int SINE_IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int RAMP_IDX_W  = $clog2(RAMP_TABLE_DEPTH);
	localparam int SINE_PROD_W = lfo_pkg::PHASE_W + SINE_IDX_W + 1;
	localparam int RAMP_PROD_W = lfo_pkg::SAMPLE_W + RAMP_IDX_W + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;
	localparam logic [2:0] ST_INC   = 3'd3;
	localparam logic [2:0] ST_SHAPE = 3'd4;
	localparam logic [2:0] ST_MUL1  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	typedef logic [lfo_pkg::SAMPLE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];
	typedef logic [lfo_pkg::PHASE_W-1:0]  ramp_rom_t [RAMP_TABLE_DEPTH];

	// round(0.5 + 0.5 * sin) in Q0.16, built from quadrant-folded series
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] t;
		logic [63:0] w;
		logic [63:0] s;
		logic [63:0] u;
		logic [1:0]  quad;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			t = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
			quad = t[31:30];
			w = t & (lfo_pkg::ONE_Q30 - 64'd1);
			if (quad[0])
				w = lfo_pkg::ONE_Q30 - w;
			s = lfo_pkg::sin_q30((w * lfo_pkg::HALF_PI_Q30) >> 30);
			if (s > lfo_pkg::ONE_Q30)
				s = lfo_pkg::ONE_Q30;
			u = quad[1] ? (lfo_pkg::ONE_Q30 - s) : (lfo_pkg::ONE_Q30 + s);
			u = (u + (64'd1 << 14)) >> 15;
			rom[i] = (u > 64'd65535) ? 16'hFFFF : u[15:0];
		end
		return rom;
	endfunction

	// ratio^(-j/depth) in Q2.30 as a power of two times exp(-frac*ln2)
	function automatic ramp_rom_t build_ramp_rom();
		ramp_rom_t   rom;
		logic [63:0] lg;
		logic [63:0] y;
		logic [63:0] sh;
		logic [63:0] e;
		lg = lfo_pkg::log2_q30(64'(RAMP_TIME_RATIO));
		for (int i = 0; i < RAMP_TABLE_DEPTH; i++) begin
			y = (lg * 64'(i)) / 64'(RAMP_TABLE_DEPTH);
			sh = y >> 30;
			e = lfo_pkg::exp_neg_q30(((y & (lfo_pkg::ONE_Q30 - 64'd1)) *
				lfo_pkg::LN2_Q30) >> 30);
			rom[i] = (sh >= 64'd40) ? '0 : 32'(e >> sh);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam ramp_rom_t RAMP_ROM = build_ramp_rom();

	// configuration
	logic [lfo_pkg::MODE_W-1:0]   wave_mode_q;
	logic [lfo_pkg::SAMPLE_W-1:0] speed_q;
	logic [lfo_pkg::SAMPLE_W-1:0] depth_q;
	logic [lfo_pkg::PHASE_W-1:0]  slow_step_q;
	logic [lfo_pkg::PHASE_W-1:0]  fast_step_q;
	logic [lfo_pkg::PHASE_W-1:0]  ramp_step_q;

	// oscillator and envelope state
	logic [lfo_pkg::PHASE_W-1:0]  free_phase_q;
	logic [lfo_pkg::PHASE_W-1:0]  trig_phase_q;
	logic [lfo_pkg::PHASE_W-1:0]  ramp_q;
	logic                         running_q;

	// per-word working registers
	logic [2:0]                   state_q;
	logic [2:0]                   state_d;
	logic [lfo_pkg::SAMPLE_W-1:0] amount_q;
	logic [SINE_IDX_W-1:0]        sine_idx_q;
	logic [RAMP_IDX_W-1:0]        ramp_idx_q;
	logic [lfo_pkg::SAMPLE_W-1:0] sine_q;
	logic [lfo_pkg::PHASE_W-1:0]  factor_q;
	logic                         out_valid_q;
	logic [lfo_pkg::SAMPLE_W-1:0] level_q;

	logic                         accept;
	logic                         free_mode;
	logic                         shape_down;
	logic                         ramp_active;
	logic                         out_free;
	logic [lfo_pkg::PHASE_W-1:0]  phase_sel;
	logic [lfo_pkg::PHASE_W-1:0]  ramp_eff;
	logic [SINE_PROD_W-1:0]       sine_prod;
	logic [RAMP_PROD_W-1:0]       ramp_prod;
	logic [lfo_pkg::PHASE_W+1:0]  ramp_sum;
	logic [lfo_pkg::PHASE_W-1:0]  ramp_next;
	logic [lfo_pkg::SAMPLE_W-1:0] level_d;
	logic                         phase_upd;
	logic                         ramp_upd;
	logic                         out_load;

	lfo_pkg::mul_req_t            mul_req;
	logic [lfo_pkg::MUL_W-1:0]    mul_a;
	logic [lfo_pkg::MUL_W-1:0]    mul_b;
	logic                         mul_busy;
	logic [lfo_pkg::MUL_P_W-1:0]  mul_p;

	lfo_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	assign accept     = events.valid && events.ready;
	assign free_mode  = (wave_mode_q == lfo_pkg::MODE_SLOW_SINE) ||
		(wave_mode_q == lfo_pkg::MODE_FAST_SINE);
	assign shape_down = (wave_mode_q == lfo_pkg::MODE_RAMP_DOWN) ||
		(wave_mode_q == lfo_pkg::MODE_LIN_DOWN);
	assign ramp_active = running_q && (ramp_q < lfo_pkg::RAMP_ONE);
	assign out_free   = !out_valid_q || samples.ready;
	assign ramp_eff   = shape_down ? (lfo_pkg::RAMP_ONE - ramp_q) : ramp_q;

	assign phase_sel = free_mode ? free_phase_q : trig_phase_q;
	assign sine_prod = SINE_PROD_W'(phase_sel) * SINE_PROD_W'(SINE_TABLE_DEPTH);
	assign ramp_prod = RAMP_PROD_W'(amount_q) * RAMP_PROD_W'(RAMP_TABLE_DEPTH);

	// add (step * factor) >> 30 and saturate at 1.0
	assign ramp_sum  = {2'b00, ramp_q} + mul_p[63:30];
	assign ramp_next = (ramp_sum > (lfo_pkg::PHASE_W + 2)'(lfo_pkg::RAMP_ONE)) ?
		lfo_pkg::RAMP_ONE : ramp_sum[lfo_pkg::PHASE_W-1:0];

	always_comb begin
		unique case (wave_mode_q)
			lfo_pkg::MODE_SLOW_SINE,
			lfo_pkg::MODE_FAST_SINE,
			lfo_pkg::MODE_RAMP_UP,
			lfo_pkg::MODE_RAMP_DOWN: level_d = mul_p[47:32];
			lfo_pkg::MODE_LIN_UP,
			lfo_pkg::MODE_LIN_DOWN:  level_d = mul_p[62:47];
			default:                 level_d = '0;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mul_req   = '0;
		mul_a     = '0;
		mul_b     = '0;
		phase_upd = 1'b0;
		ramp_upd  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (events.valid)
					state_d = ST_ADDR;
			end
			ST_ADDR: begin
				// phase step = full_step * speed
				mul_req.start  = 1'b1;
				mul_req.digits = lfo_pkg::MUL_HALF_DIGITS;
				mul_a = (wave_mode_q == lfo_pkg::MODE_SLOW_SINE) ? slow_step_q : fast_step_q;
				mul_b = lfo_pkg::MUL_W'(speed_q);
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (!mul_busy) begin
					phase_upd = 1'b1;
					if (free_mode) begin
						mul_req.start  = 1'b1;
						mul_req.digits = lfo_pkg::MUL_HALF_DIGITS;
						mul_a = lfo_pkg::MUL_W'(depth_q);
						mul_b = lfo_pkg::MUL_W'(sine_q);
						state_d = ST_FIN;
					end else if (ramp_active) begin
						mul_req.start  = 1'b1;
						mul_req.digits = lfo_pkg::MUL_FULL_DIGITS;
						mul_a = ramp_step_q;
						mul_b = factor_q;
						state_d = ST_INC;
					end else begin
						state_d = ST_SHAPE;
					end
				end
			end
			ST_INC: begin
				if (!mul_busy) begin
					ramp_upd = 1'b1;
					state_d  = ST_SHAPE;
				end
			end
			ST_SHAPE: begin
				unique case (wave_mode_q)
					lfo_pkg::MODE_RAMP_UP,
					lfo_pkg::MODE_RAMP_DOWN: begin
						mul_req.start  = 1'b1;
						mul_req.digits = lfo_pkg::MUL_HALF_DIGITS;
						mul_a = ramp_eff;
						mul_b = lfo_pkg::MUL_W'(sine_q);
						state_d = ST_MUL1;
					end
					lfo_pkg::MODE_LIN_UP,
					lfo_pkg::MODE_LIN_DOWN: begin
						mul_req.start  = 1'b1;
						mul_req.digits = lfo_pkg::MUL_HALF_DIGITS;
						mul_a = ramp_eff;
						mul_b = lfo_pkg::MUL_W'(depth_q);
						state_d = ST_FIN;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_MUL1: begin
				// scale (sine * ramp) >> 31 by depth
				if (!mul_busy) begin
					mul_req.start  = 1'b1;
					mul_req.digits = lfo_pkg::MUL_HALF_DIGITS;
					mul_a = lfo_pkg::MUL_W'(depth_q);
					mul_b = lfo_pkg::MUL_W'(mul_p[62:47]);
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!mul_busy && out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= '0;
			speed_q     <= '0;
			depth_q     <= '0;
			slow_step_q <= '0;
			fast_step_q <= '0;
			ramp_step_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lfo_pkg::REG_WAVE_MODE:         wave_mode_q <= cfg_wdata[lfo_pkg::MODE_W-1:0];
				lfo_pkg::REG_SPEED:             speed_q     <= cfg_wdata[lfo_pkg::SAMPLE_W-1:0];
				lfo_pkg::REG_DEPTH:             depth_q     <= cfg_wdata[lfo_pkg::SAMPLE_W-1:0];
				lfo_pkg::REG_SLOW_FULL_STEP:    slow_step_q <= cfg_wdata;
				lfo_pkg::REG_FAST_FULL_STEP:    fast_step_q <= cfg_wdata;
				lfo_pkg::REG_FASTEST_RAMP_STEP: ramp_step_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_phase_q <= '0;
			trig_phase_q <= '0;
			ramp_q       <= '0;
			running_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// triggers only act in the ramp modes; both clear the ramp, attack wins over decay
			if (accept && !free_mode) begin
				if (events.decay_trigger || events.attack_trigger)
					ramp_q <= '0;
				if (events.attack_trigger) begin
					running_q    <= 1'b1;
					trig_phase_q <= '0;
				end else if (events.decay_trigger) begin
					running_q <= 1'b0;
				end
			end
			if (phase_upd) begin
				if (free_mode)
					free_phase_q <= free_phase_q + mul_p[63:32];
				else
					trig_phase_q <= trig_phase_q + mul_p[63:32];
			end
			if (ramp_upd)
				ramp_q <= ramp_next;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (samples.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			amount_q <= events.ramp_amount;
		if (state_q == ST_ADDR) begin
			sine_idx_q <= sine_prod[lfo_pkg::PHASE_W +: SINE_IDX_W];
			ramp_idx_q <= ramp_prod[lfo_pkg::SAMPLE_W +: RAMP_IDX_W];
		end
		// registered table reads
		sine_q   <= SINE_ROM[sine_idx_q];
		factor_q <= RAMP_ROM[ramp_idx_q];
		if (out_load)
			level_q <= level_d;
	end

	assign events.ready  = (state_q == ST_IDLE);
	assign samples.valid = out_valid_q;
	assign samples.level = level_q;

endmodule

`default_nettype wire

/* sv/lfo_smul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_smul: digit-serial unsigned multiplier
// Shift-add, one 2-bit digit of b per cycle. After n digits p holds
// a * b * 4^(16 - n), so a 16-bit b run over 8 digits lands shifted by 16.
// ----------------------------------------------------------------------------
module lfo_smul (
	input  wire                              clk,
	input  wire                              arst_n,
	input  lfo_pkg::mul_req_t                req,
	input  wire  [lfo_pkg::MUL_W-1:0]        a,
	input  wire  [lfo_pkg::MUL_W-1:0]        b,
	output logic                             busy,
	output logic [lfo_pkg::MUL_P_W-1:0]      p
);

	logic [lfo_pkg::MUL_W-1:0]     a_q;
	logic [lfo_pkg::MUL_W-1:0]     b_q;
	logic [lfo_pkg::MUL_P_W-1:0]   p_q;
	logic [lfo_pkg::MUL_CNT_W-1:0] cnt_q;

	logic [lfo_pkg::MUL_W+1:0] pp;
	logic [lfo_pkg::MUL_W+1:0] sum;

	// partial product of one radix-4 digit
	assign pp = (b_q[0] ? {2'b00, a_q} : '0) + (b_q[1] ? {1'b0, a_q, 1'b0} : '0);
	assign sum = {2'b00, p_q[lfo_pkg::MUL_P_W-1:lfo_pkg::MUL_W]} + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.digits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (cnt_q != '0) begin
			// add the digit into the upper half, then shift the product right
			p_q <= {sum, p_q[lfo_pkg::MUL_W-1:lfo_pkg::DIGIT_W]};
			b_q <= b_q >> lfo_pkg::DIGIT_W;
		end
	end

	assign busy = (cnt_q != '0);
	assign p    = p_q;

endmodule

`default_nettype wire
